>>> design/tlcl_pkg.sv
// shared types, codes and constants for the text line column layout block
package tlcl_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  // configuration reset values
  localparam logic [6:0]  RST_WIDTH = 7'd30;
  localparam logic [8:0]  RST_TAB   = 9'd4;
  localparam logic [1:0]  RST_ENC   = 2'd0;
  localparam logic [15:0] RST_SKIP  = 16'd0;

  // saturation limit of the screen column
  localparam logic signed [17:0] COL_MAX = 18'sd131071;

  // special bytes
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_LF  = 8'h0a;
  localparam logic [7:0] BYTE_NUL = 8'h00;

  // lead byte ranges
  localparam logic [7:0] SJIS_LO1 = 8'h81;
  localparam logic [7:0] SJIS_HI1 = 8'h9f;
  localparam logic [7:0] SJIS_LO2 = 8'he0;
  localparam logic [7:0] SJIS_HI2 = 8'hfc;
  localparam logic [7:0] EUC_LO   = 8'ha1;
  localparam logic [7:0] EUC_HI   = 8'hfe;

  typedef enum logic [1:0] {
    REG_WIDTH = 2'd0,
    REG_TAB   = 2'd1,
    REG_ENC   = 2'd2,
    REG_SKIP  = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ENC_ASCII = 2'd0,
    ENC_SJIS  = 2'd1,
    ENC_EUC   = 2'd2
  } enc_t;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_CHAR = 3'd1,
    KIND_PAIR = 3'd2,
    KIND_FILL = 3'd3,
    KIND_EOL  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    CLS_PLAIN = 2'd0,
    CLS_TAB   = 2'd1,
    CLS_LEAD  = 2'd2,
    CLS_TERM  = 2'd3
  } cls_t;

  typedef struct packed {
    logic [6:0]  width;
    logic [8:0]  tab_size;
    logic [1:0]  encoding;
    logic [15:0] skip;
  } cfg_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] column;
    logic [6:0] fill_count;
    logic [7:0] char_first;
    logic [7:0] char_second;
    logic [6:0] line_length;
    logic       end_of_text;
  } result_t;

endpackage

>>> design/tlcl_front.sv
// front end: classifies each incoming byte before it is queued
module tlcl_front (
  input  logic            in_valid,
  input  logic [7:0]      text_byte,
  input  logic [1:0]      encoding,
  output logic            push,
  output tlcl_pkg::item_t item
);
  import tlcl_pkg::*;

  logic is_lead;

  always_comb begin
    unique case (enc_t'(encoding))
      ENC_SJIS: is_lead = (text_byte >= SJIS_LO1 && text_byte <= SJIS_HI1) ||
                          (text_byte >= SJIS_LO2 && text_byte <= SJIS_HI2);
      ENC_EUC:  is_lead = text_byte >= EUC_LO && text_byte <= EUC_HI;
      default:  is_lead = 1'b0;
    endcase
  end

  always_comb begin
    item.data = text_byte;
    priority if (text_byte == BYTE_LF || text_byte == BYTE_NUL) begin
      item.cls = CLS_TERM;
    end else if (text_byte == BYTE_TAB) begin
      item.cls = CLS_TAB;
    end else if (is_lead) begin
      item.cls = CLS_LEAD;
    end else begin
      item.cls = CLS_PLAIN;
    end
  end

  assign push = in_valid;

endmodule

>>> design/tlcl_fifo.sv
// short item queue between the front and back ends
module tlcl_fifo #(
  parameter int DEPTH = tlcl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tlcl_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output tlcl_pkg::item_t head_item
);
  import tlcl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> design/tlcl_back.sv
// back end: column state, placement of each item and the result register
module tlcl_back (
  input  logic              clk,
  input  logic              rst,
  input  tlcl_pkg::cfg_t    cfg,
  input  logic              restart,
  input  logic [15:0]       restart_skip,
  input  logic              head_valid,
  input  tlcl_pkg::item_t   head_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output tlcl_pkg::result_t result
);
  import tlcl_pkg::*;

  logic signed [17:0] screen_column;
  logic [8:0]         tab_phase;
  logic               lead_pending;
  logic [7:0]         lead_byte;

  logic signed [17:0] screen_column_next;
  logic [8:0]         tab_phase_next;
  logic               lead_pending_next;
  logic [7:0]         lead_byte_next;
  result_t            result_next;

  logic [8:0]         teff;
  logic signed [18:0] x;
  logic signed [18:0] w;
  logic signed [18:0] wm1;
  logic signed [17:0] col_a1;
  logic signed [17:0] col_a2;
  logic [9:0]         psum1;
  logic [9:0]         psum2;
  logic [8:0]         ph1;
  logic [8:0]         ph2;
  logic [8:0]         tab_n;
  logic signed [18:0] tab_end;
  logic signed [18:0] tab_s;
  logic signed [18:0] tab_e;
  logic signed [18:0] tab_fill;
  logic signed [17:0] line_col;

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    teff     = (cfg.tab_size == '0) ? 9'd1 : cfg.tab_size;
    x        = {screen_column[17], screen_column};
    w        = signed'({12'd0, cfg.width});
    wm1      = w - 19'sd1;
    line_col = -signed'({2'd0, cfg.skip});

    // one and two single-column advances
    col_a1 = (screen_column < COL_MAX) ? screen_column + 18'sd1 : screen_column;
    col_a2 = (col_a1 < COL_MAX) ? col_a1 + 18'sd1 : col_a1;
    psum1  = {1'b0, tab_phase} + 10'd1;
    ph1    = (psum1 >= {1'b0, teff}) ? 9'd0 : psum1[8:0];
    psum2  = {1'b0, ph1} + 10'd1;
    ph2    = (psum2 >= {1'b0, teff}) ? 9'd0 : psum2[8:0];

    // tab span clipped to the visible window
    tab_n    = (tab_phase < teff) ? teff - tab_phase : 9'd1;
    tab_end  = x + signed'({10'd0, tab_n});
    tab_s    = (x < 19'sd0) ? 19'sd0 : x;
    tab_e    = (tab_end > w) ? w : tab_end;
    tab_fill = tab_e - tab_s;
  end

  always_comb begin
    screen_column_next = screen_column;
    tab_phase_next     = tab_phase;
    lead_pending_next  = lead_pending;
    lead_byte_next     = lead_byte;
    result_next        = '0;
    result_next.kind   = KIND_NONE;

    priority if (head_item.cls == CLS_TERM) begin
      result_next.kind = KIND_EOL;
      if (x > w) begin
        result_next.line_length = cfg.width;
      end else if (x < 19'sd0) begin
        result_next.line_length = '0;
      end else begin
        result_next.line_length = x[6:0];
      end
      result_next.end_of_text = (head_item.data == BYTE_NUL);
      screen_column_next = line_col;
      tab_phase_next     = '0;
      lead_pending_next  = 1'b0;
      lead_byte_next     = '0;
    end else if (lead_pending) begin
      priority if (x == -19'sd1 && w > 19'sd0) begin
        result_next.kind       = KIND_FILL;
        result_next.fill_count = 7'd1;
      end else if (x >= 19'sd0 && x < wm1) begin
        result_next.kind        = KIND_PAIR;
        result_next.column      = x[6:0];
        result_next.char_first  = lead_byte;
        result_next.char_second = head_item.data;
      end else if (x >= 19'sd0 && x == wm1) begin
        result_next.kind       = KIND_FILL;
        result_next.column     = x[6:0];
        result_next.fill_count = 7'd1;
      end else begin
        result_next.kind = KIND_NONE;
      end
      lead_pending_next  = 1'b0;
      lead_byte_next     = '0;
      screen_column_next = col_a2;
      tab_phase_next     = ph2;
    end else begin
      unique case (head_item.cls)
        CLS_TAB: begin
          result_next.kind = KIND_FILL;
          if (tab_e > tab_s) begin
            result_next.column     = tab_s[6:0];
            result_next.fill_count = tab_fill[6:0];
          end
          screen_column_next = (tab_end > signed'({COL_MAX[17], COL_MAX})) ? COL_MAX
                                                                          : tab_end[17:0];
          tab_phase_next = '0;
        end
        CLS_LEAD: begin
          lead_pending_next = 1'b1;
          lead_byte_next    = head_item.data;
        end
        default: begin
          if (x >= 19'sd0 && x < w) begin
            result_next.kind       = KIND_CHAR;
            result_next.column     = x[6:0];
            result_next.char_first = head_item.data;
          end
          screen_column_next = col_a1;
          tab_phase_next     = ph1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_column <= '0;
      tab_phase     <= '0;
      lead_pending  <= 1'b0;
      lead_byte     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (restart) begin
        screen_column <= -signed'({2'd0, restart_skip});
        tab_phase     <= '0;
        lead_pending  <= 1'b0;
        lead_byte     <= '0;
      end else if (pop) begin
        screen_column <= screen_column_next;
        tab_phase     <= tab_phase_next;
        lead_pending  <= lead_pending_next;
        lead_byte     <= lead_byte_next;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

endmodule

>>> design/text_line_column_layout_top.sv
// top level of the text line column layout block
//
// lays a text byte stream out into screen columns, one byte per item
// input channel: in_valid / in_ready with text_byte
// output channel: out_valid / out_ready with kind, column, fill_count,
//   char_first, char_second, line_length and end_of_text, one result per item
// config port: cfg_we writes cfg_data into the register picked by cfg_index
//   (visible width, tab size, encoding, horizontal skip); writing the
//   horizontal skip also restarts the line
// the front end classifies bytes into a two-entry queue, the back end holds
//   the column, tab phase and pending lead byte and updates them as each item is popped
// an accepted item waits in the queue; its result is registered when it is popped
// throughput: one item per cycle while the receiver does not stall, set by the column update loop
//   in the back end
// a stalled receiver holds the result register; the queue keeps taking items
//   until it is full, then in_ready drops
// reset: registers return to width 30, tab size 4, ascii, no skip; the line
//   restarts at column zero and queue and result register are empty
module text_line_column_layout_top #(
  parameter int QUEUE_DEPTH = tlcl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [6:0]  column,
  output logic [6:0]  fill_count,
  output logic [7:0]  char_first,
  output logic [7:0]  char_second,
  output logic [6:0]  line_length,
  output logic        end_of_text,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tlcl_pkg::*;

  cfg_t    cfg;
  logic    push;
  item_t   push_item;
  logic    full;
  logic    pop;
  logic    head_valid;
  item_t   head_item;
  result_t result;
  logic    restart;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width    <= RST_WIDTH;
      cfg.tab_size <= RST_TAB;
      cfg.encoding <= RST_ENC;
      cfg.skip     <= RST_SKIP;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_WIDTH: cfg.width    <= cfg_data[6:0];
        REG_TAB:   cfg.tab_size <= cfg_data[8:0];
        REG_ENC:   cfg.encoding <= cfg_data[1:0];
        REG_SKIP:  cfg.skip     <= cfg_data;
        default:   cfg.skip     <= cfg.skip;
      endcase
    end
  end

  // a new scroll position starts the line over
  assign restart = cfg_we && (reg_index_t'(cfg_index) == REG_SKIP);

  assign in_ready = !full;

  tlcl_front u_front (
    .in_valid  (in_valid),
    .text_byte (text_byte),
    .encoding  (cfg.encoding),
    .push      (push),
    .item      (push_item)
  );

  tlcl_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  tlcl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .restart      (restart),
    .restart_skip (cfg_data),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result       (result)
  );

  // result fields onto the output ports
  assign kind        = result.kind;
  assign column      = result.column;
  assign fill_count  = result.fill_count;
  assign char_first  = result.char_first;
  assign char_second = result.char_second;
  assign line_length = result.line_length;
  assign end_of_text = result.end_of_text;

endmodule

>>> design/tlcl_checker.sv
// port-level checks for the text line column layout block, with its bind
module tlcl_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] kind,
  input logic [6:0] column,
  input logic [6:0] fill_count,
  input logic [7:0] char_first,
  input logic       end_of_text
);
  import tlcl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(column))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind <= KIND_EOL)
    else $error("result kind out of range");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_NONE || kind == KIND_EOL) |->
      column == '0 && fill_count == '0 && char_first == '0)
    else $error("placement fields set on empty or end of line result");

  a_eot_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_text |-> kind == KIND_EOL)
    else $error("end of text without end of line");

endmodule

bind text_line_column_layout_top tlcl_checker u_tlcl_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .kind        (kind),
  .column      (column),
  .fill_count  (fill_count),
  .char_first  (char_first),
  .end_of_text (end_of_text)
);
